// ----- rtl/afc_pkg.sv -----
// Shared types, constants and helpers of the printable-ASCII affine cipher.
package afc_pkg;

	// Printable character set: codes 32..126, 95 symbols
	localparam logic [6:0] AFC_MOD = 7'd95;
	localparam logic [7:0] AFC_BASE_CODE = 8'd32;
	localparam logic [7:0] AFC_TOP_CODE = 8'd126;

	// Reciprocal of 95 for values below 2^14: q = (v * RECIP) >> SHIFT is exact
	localparam logic [13:0] AFC_RECIP = 14'd11038;
	localparam int AFC_RECIP_SHIFT = 20;

	// Default queue depth between front and back
	localparam int AFC_QUEUE_DEPTH = 2;

	// Mode codes
	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	// Register indexes
	localparam logic REG_KEY_MULT = 1'b0;
	localparam logic REG_KEY_ADD = 1'b1;

	// Reset values of the key registers
	localparam logic [6:0] KEY_MULT_RESET = 7'd1;
	localparam logic [6:0] KEY_ADD_RESET = 7'd0;

	// Classified item as it sits in the queue
	typedef struct packed {
		logic mode;
		logic printable;
		logic [6:0] sym;
		logic [7:0] raw;
	} afc_item_t;

	// Key status from the inverse unit to the back end
	typedef struct packed {
		logic ready;
		logic key_ok;
		logic [6:0] inv;
	} afc_key_t;

	// Per-item info carried alongside the arithmetic pipeline
	typedef struct packed {
		logic xform;
		logic printable;
		logic key_ok;
		logic [7:0] raw;
	} afc_meta_t;

	// Reduce a 7-bit value mod 95 (one compare and subtract)
	function automatic logic [6:0] afc_mod95(input logic [6:0] v);
		afc_mod95 = (v >= AFC_MOD) ? v - AFC_MOD : v;
	endfunction

endpackage

// ----- rtl/afc_front.sv -----
// Input stage: registers and classifies each item, then hands it to the queue.
module afc_front import afc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  logic [7:0] in_char,
	output logic push,
	output afc_item_t push_item,
	input  logic queue_full
);

	logic vld_q;
	afc_item_t item_q;

	assign push = vld_q && !queue_full;
	assign in_ready = !vld_q || push;
	assign push_item = item_q;

	// Valid flag of the holding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	// Classify: printable range and symbol offset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q.mode <= mode;
			item_q.raw <= in_char;
			item_q.printable <= (in_char >= AFC_BASE_CODE) && (in_char <= AFC_TOP_CODE);
			item_q.sym <= 7'(in_char - AFC_BASE_CODE);
		end
	end

endmodule

// ----- rtl/afc_queue.sv -----
// Short FIFO of classified items between the front and the back end.
module afc_queue import afc_pkg::*; #(
	parameter int DEPTH = AFC_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  afc_item_t push_item,
	input  logic pop,
	output afc_item_t head,
	output logic empty,
	output logic full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	afc_item_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == CW'(DEPTH));
	assign head = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/afc_inv.sv -----
// Extended Euclid unit: finds the inverse of the key multiplier mod 95 and its gcd check.
module afc_inv import afc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic key_wr,
	input  logic [6:0] key_mult_red,
	output afc_key_t key_stat
);

	logic busy_q;
	logic done_q;
	logic ok_q;
	logic [6:0] inv_q;
	logic [6:0] r0_q;
	logic [6:0] r1_q;
	logic signed [8:0] t0_q;
	logic signed [8:0] t1_q;
	logic start;
	logic finish;
	logic signed [8:0] t_pos;
	logic [6:0] t_fix;

	assign start = !key_wr && !busy_q && !done_q;
	assign finish = busy_q && (r1_q == '0);

	// Bring the final coefficient into 0..94
	assign t_pos = (t0_q < 0) ? t0_q + 9'sd95 : t0_q;
	assign t_fix = (t_pos >= 9'sd95) ? 7'(t_pos - 9'sd95) : 7'(t_pos);

	// Control and cached results; a key write drops the cache and restarts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ok_q <= 1'b0;
			inv_q <= '0;
		end else if (key_wr) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (finish) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
			ok_q <= (r0_q == 7'd1);
			inv_q <= t_fix;
		end
	end

	// One subtract or one swap per cycle; a run of subtracts forms each quotient
	always_ff @(posedge clk) begin
		if (start) begin
			r0_q <= AFC_MOD;
			r1_q <= key_mult_red;
			t0_q <= 9'sd0;
			t1_q <= 9'sd1;
		end else if (busy_q && !finish) begin
			if (r0_q >= r1_q) begin
				r0_q <= r0_q - r1_q;
				t0_q <= t0_q - t1_q;
			end else begin
				r0_q <= r1_q;
				r1_q <= r0_q;
				t0_q <= t1_q;
				t1_q <= t0_q;
			end
		end
	end

	assign key_stat.ready = done_q;
	assign key_stat.key_ok = ok_q;
	assign key_stat.inv = inv_q;

endmodule

// ----- rtl/afc_back.sv -----
// Back end: multiply, reduce mod 95 and present the result item.
module afc_back import afc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  afc_item_t head,
	input  logic empty,
	output logic pop,
	input  afc_key_t key_stat,
	input  logic [6:0] key_mult_red,
	input  logic [6:0] key_add_red,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] out_char,
	output logic char_ok,
	output logic key_ok
);

	logic advance;
	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	afc_meta_t meta_s1;
	afc_meta_t meta_s2;
	logic [13:0] prod_s1;
	logic [6:0] add_s1;
	logic [13:0] val_s2;
	logic [6:0] quo_s2;
	logic [7:0] char_s3;
	afc_meta_t meta_s3;

	logic [7:0] diff;
	logic [6:0] sym_dec;
	logic [6:0] opnd;
	logic [6:0] mult;
	logic [13:0] val;
	logic [27:0] recip_prod;
	logic [13:0] rem_full;

	// Whole pipeline moves when the output slot is free or being taken
	assign advance = !vld_s3 || out_ready;
	assign pop = advance && key_stat.ready && !empty;

	// Decrypt pre-step: (y - b) mod 95
	assign diff = {1'b0, head.sym} + ((head.sym < key_add_red) ? {1'b0, AFC_MOD} : 8'd0)
		- {1'b0, key_add_red};
	assign sym_dec = diff[6:0];
	assign opnd = (head.mode == MODE_DECRYPT) ? sym_dec : head.sym;
	assign mult = (head.mode == MODE_DECRYPT) ? key_stat.inv : key_mult_red;

	// Stage 1: product
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1 <= 14'(opnd) * 14'(mult);
			add_s1 <= (head.mode == MODE_DECRYPT) ? 7'd0 : key_add_red;
			meta_s1.raw <= head.raw;
			meta_s1.printable <= head.printable;
			meta_s1.key_ok <= key_stat.key_ok;
			meta_s1.xform <= head.printable
				&& ((head.mode == MODE_ENCRYPT) || key_stat.key_ok);
		end
	end

	// Stage 2: add and estimate quotient by reciprocal
	assign val = prod_s1 + 14'(add_s1);
	assign recip_prod = 28'(val) * 28'(AFC_RECIP);

	always_ff @(posedge clk) begin
		if (advance) begin
			val_s2 <= val;
			quo_s2 <= recip_prod[AFC_RECIP_SHIFT+6:AFC_RECIP_SHIFT];
			meta_s2 <= meta_s1;
		end
	end

	// Stage 3: remainder and output register
	assign rem_full = val_s2 - 14'(quo_s2) * 14'(AFC_MOD);

	always_ff @(posedge clk) begin
		if (advance) begin
			char_s3 <= meta_s2.xform ? 8'(rem_full[6:0]) + AFC_BASE_CODE : meta_s2.raw;
			meta_s3 <= meta_s2;
		end
	end

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_char = char_s3;
	assign char_ok = meta_s3.printable;
	assign key_ok = meta_s3.key_ok;

endmodule

// ----- rtl/affine_cipher_printable_ascii_core.sv -----
// Affine cipher over printable ASCII (32..126): encrypt (a*x+b) mod 95, decrypt with cached inverse.
// Each item is one byte plus a mode bit and yields one result item. Items flow at one per
// cycle, unless out_ready is low or the inverse is not ready, through a front register, a short
// queue and a three-stage multiply/reduce pipeline. After reset or any write to key_mult
// or key_add, an iterative extended-Euclid unit recomputes the inverse of key_mult mod 95 and
// its gcd check, one subtract or swap step per cycle; queued items wait for it, input keeps
// filling the queue meanwhile. Bytes outside 32..126 pass through with char_ok low; decrypt
// under a key whose multiplier shares a factor with 95 passes the byte through with key_ok
// low. Keys 95..127 are used reduced mod 95.
// Registers: key_mult at address 0, key_add at address 4; write them only while idle.
module affine_cipher_printable_ascii_core import afc_pkg::*; #(
	parameter int QUEUE_DEPTH = AFC_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	// configuration port
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// input items
	input  logic in_valid,
	output logic in_ready,
	input  logic mode,
	input  logic [7:0] in_char,
	// result items
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] out_char,
	output logic char_ok,
	output logic key_ok
);

	logic [6:0] key_mult_q;
	logic [6:0] key_add_q;
	logic [6:0] key_mult_red;
	logic [6:0] key_add_red;
	logic cfg_wr;
	logic push;
	logic pop;
	logic empty;
	logic full;
	afc_item_t push_item;
	afc_item_t head;
	afc_key_t key_stat;

	// Register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = {25'd0, (paddr[2] == REG_KEY_ADD) ? key_add_q : key_mult_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mult_q <= KEY_MULT_RESET;
			key_add_q <= KEY_ADD_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_KEY_MULT) begin
				key_mult_q <= pwdata[6:0];
			end else begin
				key_add_q <= pwdata[6:0];
			end
		end
	end

	assign key_mult_red = afc_mod95(key_mult_q);
	assign key_add_red = afc_mod95(key_add_q);

	afc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.in_char(in_char),
		.push(push),
		.push_item(push_item),
		.queue_full(full)
	);

	afc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.head(head),
		.empty(empty),
		.full(full)
	);

	afc_inv u_inv (
		.clk(clk),
		.arst_n(arst_n),
		.key_wr(cfg_wr),
		.key_mult_red(key_mult_red),
		.key_stat(key_stat)
	);

	afc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.key_stat(key_stat),
		.key_mult_red(key_mult_red),
		.key_add_red(key_add_red),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_char(out_char),
		.char_ok(char_ok),
		.key_ok(key_ok)
	);

	// A key write always drops the cached inverse
	a_key_wr_drops_cache: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !key_stat.ready)
		else $error("inverse cache still valid after key write");

	// A transformed byte lands in the printable range
	a_out_printable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_ok |-> (out_char >= AFC_BASE_CODE) && (out_char <= AFC_TOP_CODE))
		else $error("printable input produced non-printable output");

	// A non-printable byte comes back non-printable
	a_out_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_ok |-> (out_char < AFC_BASE_CODE) || (out_char > AFC_TOP_CODE))
		else $error("non-printable input produced printable output");

	// The cached inverse holds while the cache stays valid
	a_inv_stable: assert property (@(posedge clk) disable iff (!arst_n)
		key_stat.ready && $past(key_stat.ready) |-> $stable(key_stat.inv))
		else $error("cached inverse changed while valid");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the printable-ASCII affine cipher core.
module testbench import afc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 20;
	localparam int ITEMS_PER_KEY = 95;
	localparam int KEYS_PER_PHASE = 7;

	// Expected fields of one result item
	typedef struct {
		logic [7:0] ch;
		logic printable;
		logic kok;
	} cipher_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_ready;
	logic mode;
	logic [7:0] in_char;
	logic out_valid;
	logic out_ready;
	logic [7:0] out_char;
	logic char_ok;
	logic key_ok;

	// Predictor state: key registers and the derived inverse
	logic [6:0] mult_key;
	logic [6:0] add_key;
	int unsigned mult_inv;
	logic key_coprime;

	cipher_result_t pending_q[$];
	int err_count;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;

	affine_cipher_printable_ascii_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.in_char(in_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_char(out_char),
		.char_ok(char_ok),
		.key_ok(key_ok)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		err_count++;
	endtask

	// Find the inverse of the multiplier by search; none exists for a bad key
	function automatic void derive_inverse();
		int unsigned a;
		a = mult_key % AFC_MOD;
		key_coprime = 1'b0;
		mult_inv = 0;
		for (int t = 1; t < AFC_MOD; t++) begin
			if ((a * t) % AFC_MOD == 1) begin
				key_coprime = 1'b1;
				mult_inv = t;
			end
		end
	endfunction

	function automatic cipher_result_t cipher_predict(input logic m, input logic [7:0] c);
		cipher_result_t r;
		int unsigned a, b, x;
		a = mult_key % AFC_MOD;
		b = add_key % AFC_MOD;
		x = c;
		r.ch = c;
		r.printable = (c >= AFC_BASE_CODE) && (c <= AFC_TOP_CODE);
		r.kok = key_coprime;
		if (r.printable) begin
			x = x - AFC_BASE_CODE;
			if (m == MODE_ENCRYPT) begin
				r.ch = 8'((a * x + b) % AFC_MOD + AFC_BASE_CODE);
			end else if (key_coprime) begin
				r.ch = 8'(((x + AFC_MOD - b) * mult_inv) % AFC_MOD + AFC_BASE_CODE);
			end
		end
		return r;
	endfunction

	// APB write, then read back the same register, then return the bus to idle
	task automatic set_key_reg(input logic idx, input logic [31:0] val);
		logic [31:0] want;
		want = {25'd0, val[6:0]};
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_KEY_MULT) mult_key = val[6:0];
		else add_key = val[6:0];
		derive_inverse();
		// read back
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (prdata !== want) report_mismatch("prdata", prdata, want);
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Send one item; valid stays up across back-to-back items
	task automatic send_char(input logic m, input logic [7:0] c);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		in_char <= c;
		do @(posedge clk); while (!in_ready);
		pending_q.push_back(cipher_predict(m, c));
	endtask

	// Stop sending and wait for every expected result
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_key(input logic [31:0] mult_val, input logic [31:0] add_val);
		drain();
		set_key_reg(REG_KEY_MULT, mult_val);
		set_key_reg(REG_KEY_ADD, add_val);
	endtask

	// Reset values of the key: identity cipher
	task automatic test_reset_key();
		logic [31:0] r;
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= {REG_KEY_MULT, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		r = prdata;
		if (r !== {25'd0, KEY_MULT_RESET}) report_mismatch("reset key_mult", r, KEY_MULT_RESET);
		@(posedge clk);
		penable <= 1'b0;
		paddr <= {REG_KEY_ADD, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		r = prdata;
		if (r !== {25'd0, KEY_ADD_RESET}) report_mismatch("reset key_add", r, KEY_ADD_RESET);
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		send_char(MODE_ENCRYPT, "A");
		send_char(MODE_DECRYPT, "z");
		send_char(MODE_ENCRYPT, 8'd0);
		send_char(MODE_DECRYPT, 8'd255);
	endtask

	// Field extremes, printable edges, bad keys and oversized key values
	task automatic test_special_cases();
		set_key(32'd7, 32'd3);
		send_char(MODE_ENCRYPT, 8'd32);
		send_char(MODE_ENCRYPT, 8'd126);
		send_char(MODE_DECRYPT, 8'd32);
		send_char(MODE_DECRYPT, 8'd126);
		send_char(MODE_ENCRYPT, 8'd31);
		send_char(MODE_DECRYPT, 8'd127);
		// multiplier shares a factor with the modulus
		set_key(32'd5, 32'd10);
		send_char(MODE_ENCRYPT, "M");
		send_char(MODE_DECRYPT, "M");
		send_char(MODE_DECRYPT, 8'd10);
		set_key(32'd0, 32'd0);
		send_char(MODE_ENCRYPT, "q");
		send_char(MODE_DECRYPT, "q");
		// values above 94 reduce mod 95; upper data bits ignored
		set_key(32'hFFFF_FF80 | 32'd96, 32'd127);
		send_char(MODE_ENCRYPT, "~");
		send_char(MODE_DECRYPT, " ");
		set_key(32'd127, 32'd95);
		send_char(MODE_ENCRYPT, "0");
		send_char(MODE_DECRYPT, "0");
		set_key(32'd94, 32'd94);
		send_char(MODE_ENCRYPT, 8'd126);
		send_char(MODE_DECRYPT, 8'd32);
		send_char(MODE_DECRYPT, 8'd200);
	endtask

	function automatic logic [31:0] pick_key_value();
		logic [31:0] v;
		case ($urandom_range(9, 0))
			0: v = $urandom_range(1, 0) ? 32'd0 : 32'd95;
			1: v = $urandom_range(1, 0) ? 32'd1 : ($urandom_range(1, 0) ? 32'd94 : 32'd127);
			default: v = $urandom_range(127, 0);
		endcase
		// junk in the upper bits now and then
		if ($urandom_range(3, 0) == 0) v[31:7] = 25'($urandom);
		return v;
	endfunction

	// Random stream under a series of random keys
	task automatic test_random(input int s_pct, input int r_pct);
		logic [7:0] c;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int k = 0; k < KEYS_PER_PHASE; k++) begin
			set_key(pick_key_value(), pick_key_value());
			for (int i = 0; i < ITEMS_PER_KEY; i++) begin
				if ($urandom_range(3, 0) != 0) c = 8'($urandom_range(126, 32));
				else c = 8'($urandom_range(255, 0));
				send_char(1'($urandom_range(1, 0)), c);
			end
		end
	endtask

	// Result checker and receiver stalls
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result, out_char", out_char, 0);
			end else begin
				cipher_result_t e;
				e = pending_q.pop_front();
				if (out_char !== e.ch) report_mismatch("out_char", out_char, e.ch);
				if (char_ok !== e.printable) report_mismatch("char_ok", char_ok, e.printable);
				if (key_ok !== e.kok) report_mismatch("key_ok", key_ok, e.kok);
			end
		end
		out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
	end

	// Timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		err_count = 0;
		send_idle_pct = 22;
		recv_idle_pct = 85;
		mult_key = KEY_MULT_RESET;
		add_key = KEY_ADD_RESET;
		derive_inverse();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		mode <= MODE_ENCRYPT;
		in_char <= '0;
		out_ready <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_key();
		test_special_cases();
		test_random(22, 85);
		test_random(85, 22);
		test_random(0, 0);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0 && pending_q.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
